// ===== sv/bhkv_pkg.sv =====
// ----------------------------------------------------------------------------
// bhkv_pkg
// Shared widths, codes and types of the bucketed key/value store.
// ----------------------------------------------------------------------------
package bhkv_pkg;

  localparam int KEY_W    = 64;
  localparam int VAL_W    = 64;
  localparam int KV_W     = KEY_W + VAL_W;
  localparam int REQ_W    = 2;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 12;

  localparam int CFG_W     = 9;
  localparam int CFG_MAX   = (1 << CFG_W) - 1;
  localparam int CFG_RESET = 256;

  localparam int DEF_MAX_BUCKETS      = 256;
  localparam int DEF_SLOTS_PER_BUCKET = 8;

  // bit-serial remainder: one key bit per step
  localparam int DIV_STEPS = KEY_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);
  localparam int REM_W     = CFG_W;

  typedef enum logic [REQ_W-1:0] {
    REQ_INSERT = 2'd0,
    REQ_LOOKUP = 2'd1,
    REQ_REMOVE = 2'd2,
    REQ_NOP    = 2'd3
  } req_type_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_ABSENT  = 2'd0,
    ST_PRESENT = 2'd1,
    ST_FULL    = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DIV,
    S_RDV,
    S_SCAN,
    S_DONE
  } state_t;

endpackage

// ===== sv/bhkv_if.sv =====
// ----------------------------------------------------------------------------
// bhkv_if
// Valid/ready channels for request and response beats.
// ----------------------------------------------------------------------------
interface bhkv_req_if;
  logic                          valid;
  logic                          ready;
  logic [bhkv_pkg::REQ_W-1:0]    req_type;
  logic [bhkv_pkg::KEY_W-1:0]    key;
  logic [bhkv_pkg::VAL_W-1:0]    value;

  modport source (output valid, output req_type, output key, output value, input ready);
  modport sink   (input valid, input req_type, input key, input value, output ready);
endinterface

interface bhkv_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [bhkv_pkg::STATUS_W-1:0] status;
  logic [bhkv_pkg::VAL_W-1:0]    found_value;
  logic [bhkv_pkg::COUNT_W-1:0]  entry_count;

  modport source (output valid, output status, output found_value, output entry_count,
                  input ready);
  modport sink   (input valid, input status, input found_value, input entry_count,
                  output ready);
endinterface

// ===== sv/bhkv_ram.sv =====
// ----------------------------------------------------------------------------
// bhkv_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bhkv_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== sv/bhkv_div.sv =====
// ----------------------------------------------------------------------------
// bhkv_div
// Bit-serial remainder of a 64-bit key by a 9-bit bucket count.
// ----------------------------------------------------------------------------
module bhkv_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [bhkv_pkg::KEY_W-1:0]   dividend,
  input  logic [bhkv_pkg::REM_W-1:0]   divisor,
  output logic                         done,
  output logic [bhkv_pkg::REM_W-1:0]   rem
);

  logic                           busy_r;
  logic                           done_r;
  logic [bhkv_pkg::DIV_CNT_W-1:0] cnt_r;
  logic [bhkv_pkg::KEY_W-1:0]     q_r;
  logic [bhkv_pkg::REM_W-1:0]     d_r;
  logic [bhkv_pkg::REM_W-1:0]     rem_r;
  logic [bhkv_pkg::REM_W-1:0]     rem_nxt;
  logic [bhkv_pkg::REM_W:0]       trial;
  logic [bhkv_pkg::REM_W:0]       diff;

  always_comb begin
    trial   = {rem_r, q_r[bhkv_pkg::KEY_W-1]};
    diff    = trial - {1'b0, d_r};
    rem_nxt = (trial >= {1'b0, d_r}) ? diff[bhkv_pkg::REM_W-1:0]
                                      : trial[bhkv_pkg::REM_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == bhkv_pkg::DIV_CNT_W'(bhkv_pkg::DIV_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= dividend;
      d_r   <= divisor;
      rem_r <= '0;
    end else if (busy_r) begin
      q_r   <= {q_r[bhkv_pkg::KEY_W-2:0], 1'b0};
      rem_r <= rem_nxt;
    end
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule

// ===== sv/bucketed_hash_table_kv_store_top.sv =====
// ----------------------------------------------------------------------------
// bucketed_hash_table_kv_store_top
// Key/value store with bounded buckets: insert, lookup and remove.
// ----------------------------------------------------------------------------
// One request is handled at a time. The key modulo the bucket count is
// formed one key bit per cycle, then the valid row of the bucket is read
// and its slots are read one per cycle from the key/value RAM and compared,
// and the update is written back when the response is loaded. The response
// waits in an output register, so a new request is taken while the previous
// response is still pending. After reset the block clears every row of the
// valid RAM and takes no request meanwhile; cfg writes are taken at any time
// but belong only in idle periods.
module bucketed_hash_table_kv_store_top #(
  parameter int MAX_BUCKETS      = bhkv_pkg::DEF_MAX_BUCKETS,
  parameter int SLOTS_PER_BUCKET = bhkv_pkg::DEF_SLOTS_PER_BUCKET
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [bhkv_pkg::CFG_W-1:0] cfg_wdata,
  bhkv_req_if.sink                   in_req,
  bhkv_rsp_if.source                 out_rsp
);

  localparam int TOTAL_SLOTS = MAX_BUCKETS * SLOTS_PER_BUCKET;
  localparam int BKT_W  = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
  localparam int ADDR_W = (TOTAL_SLOTS > 1) ? $clog2(TOTAL_SLOTS) : 1;
  localparam int SLOT_W = (SLOTS_PER_BUCKET > 1) ? $clog2(SLOTS_PER_BUCKET) : 1;
  localparam int SCAN_W = $clog2(SLOTS_PER_BUCKET + 1);
  localparam int ELEM_W = ($clog2(TOTAL_SLOTS + 1) > bhkv_pkg::COUNT_W) ?
                          $clog2(TOTAL_SLOTS + 1) : bhkv_pkg::COUNT_W;
  localparam logic [bhkv_pkg::CFG_W-1:0] BKT_CAP =
    (MAX_BUCKETS > bhkv_pkg::CFG_MAX) ? bhkv_pkg::CFG_W'(bhkv_pkg::CFG_MAX)
                                      : bhkv_pkg::CFG_W'(MAX_BUCKETS);

  bhkv_pkg::state_t                state_r, state_nxt;
  logic [bhkv_pkg::CFG_W-1:0]      bcount_r;
  logic [bhkv_pkg::CFG_W-1:0]      eff_bkt;
  logic [bhkv_pkg::REQ_W-1:0]      req_r;
  logic [bhkv_pkg::KEY_W-1:0]      key_r;
  logic [bhkv_pkg::VAL_W-1:0]      val_r;
  logic [BKT_W-1:0]                bucket_r;
  logic [ADDR_W-1:0]               base_r;
  logic [SCAN_W-1:0]               scan_r;
  logic [BKT_W-1:0]                clr_r;
  logic                            hit_r, free_r;
  logic [SLOT_W-1:0]               hit_idx_r, free_idx_r;
  logic [bhkv_pkg::VAL_W-1:0]      found_r;
  logic [ELEM_W-1:0]               elem_cnt_r, elem_nxt;

  logic                            out_valid_r;
  bhkv_pkg::status_t               out_status_r;
  logic [bhkv_pkg::VAL_W-1:0]      out_found_r;
  logic [bhkv_pkg::COUNT_W-1:0]    out_count_r;

  logic                            div_start, div_done;
  logic [bhkv_pkg::REM_W-1:0]      div_rem;
  logic [BKT_W-1:0]                div_bucket;

  logic                            vram_we, vram_re;
  logic [BKT_W-1:0]                vram_waddr;
  logic [SLOTS_PER_BUCKET-1:0]     vram_wdata, vram_rdata, vrow_new;
  logic                            kv_we, kv_re;
  logic [ADDR_W-1:0]               kv_waddr, kv_raddr;
  logic [bhkv_pkg::KV_W-1:0]       kv_rdata;

  logic                            clearing, ld, vwr, kvwr;
  logic [SLOT_W-1:0]               slot_j;
  logic                            act, is_ins, is_rem;
  bhkv_pkg::status_t               status_nxt;
  logic [bhkv_pkg::VAL_W-1:0]      found_nxt;
  logic [SLOT_W-1:0]               wr_idx;

  // effective bucket count: 0 acts as 1, clamp to the lesser of MAX_BUCKETS and CFG_MAX
  always_comb begin
    if (bcount_r == '0) begin
      eff_bkt = bhkv_pkg::CFG_W'(1);
    end else if (bcount_r > BKT_CAP) begin
      eff_bkt = BKT_CAP;
    end else begin
      eff_bkt = bcount_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bcount_r <= bhkv_pkg::CFG_W'(bhkv_pkg::CFG_RESET);
    end else if (cfg_we) begin
      bcount_r <= cfg_wdata;
    end
  end

  bhkv_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (in_req.key),
    .divisor  (eff_bkt),
    .done     (div_done),
    .rem      (div_rem)
  );

  assign div_bucket = BKT_W'(div_rem);

  bhkv_ram #(.WIDTH(SLOTS_PER_BUCKET), .DEPTH(MAX_BUCKETS)) u_vram (
    .clk   (clk),
    .we    (vram_we),
    .waddr (vram_waddr),
    .wdata (vram_wdata),
    .re    (vram_re),
    .raddr (bucket_r),
    .rdata (vram_rdata)
  );

  bhkv_ram #(.WIDTH(bhkv_pkg::KV_W), .DEPTH(TOTAL_SLOTS)) u_kvram (
    .clk   (clk),
    .we    (kv_we),
    .waddr (kv_waddr),
    .wdata ({key_r, val_r}),
    .re    (kv_re),
    .raddr (kv_raddr),
    .rdata (kv_rdata)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      bhkv_pkg::S_CLEAR: begin
        if (clr_r == BKT_W'(MAX_BUCKETS - 1)) state_nxt = bhkv_pkg::S_IDLE;
      end
      bhkv_pkg::S_IDLE: begin
        if (in_req.valid) state_nxt = bhkv_pkg::S_DIV;
      end
      bhkv_pkg::S_DIV: begin
        if (div_done) state_nxt = bhkv_pkg::S_RDV;
      end
      bhkv_pkg::S_RDV: begin
        state_nxt = bhkv_pkg::S_SCAN;
      end
      bhkv_pkg::S_SCAN: begin
        if (scan_r == SCAN_W'(SLOTS_PER_BUCKET)) state_nxt = bhkv_pkg::S_DONE;
      end
      bhkv_pkg::S_DONE: begin
        if (ld) state_nxt = bhkv_pkg::S_IDLE;
      end
      default: begin
        state_nxt = bhkv_pkg::S_IDLE;
      end
    endcase
  end

  // state outputs
  always_comb begin
    clearing     = (state_r == bhkv_pkg::S_CLEAR);
    in_req.ready = (state_r == bhkv_pkg::S_IDLE);
    div_start    = (state_r == bhkv_pkg::S_IDLE) && in_req.valid;
    vram_re      = (state_r == bhkv_pkg::S_RDV);
    kv_re        = (state_r == bhkv_pkg::S_SCAN) &&
                   (scan_r < SCAN_W'(SLOTS_PER_BUCKET));
    ld           = (state_r == bhkv_pkg::S_DONE) && (!out_valid_r || out_rsp.ready);
  end

  assign kv_raddr = base_r + ADDR_W'(scan_r);
  assign slot_j   = SLOT_W'(scan_r - SCAN_W'(1));

  // read-modify-write decision for the bucket
  always_comb begin
    act        = (req_r != bhkv_pkg::REQ_NOP);
    is_ins     = (req_r == bhkv_pkg::REQ_INSERT);
    is_rem     = (req_r == bhkv_pkg::REQ_REMOVE);
    status_nxt = bhkv_pkg::ST_ABSENT;
    found_nxt  = '0;
    vwr        = 1'b0;
    kvwr       = 1'b0;
    vrow_new   = vram_rdata;
    elem_nxt   = elem_cnt_r;
    wr_idx     = hit_idx_r;
    if (act && hit_r) begin
      status_nxt = bhkv_pkg::ST_PRESENT;
      found_nxt  = found_r;
      if (is_ins) begin
        kvwr = 1'b1;
      end else if (is_rem) begin
        vwr = 1'b1;
        vrow_new[hit_idx_r] = 1'b0;
        if (elem_cnt_r != '0) elem_nxt = elem_cnt_r - 1'b1;
      end
    end else if (act && is_ins) begin
      if (free_r) begin
        wr_idx = free_idx_r;
        vwr    = 1'b1;
        kvwr   = 1'b1;
        vrow_new[free_idx_r] = 1'b1;
        elem_nxt = elem_cnt_r + 1'b1;
      end else begin
        status_nxt = bhkv_pkg::ST_FULL;
      end
    end
  end

  assign vram_we    = clearing || (ld && vwr);
  assign vram_waddr = clearing ? clr_r : bucket_r;
  assign vram_wdata = clearing ? '0 : vrow_new;
  assign kv_we      = ld && kvwr;
  assign kv_waddr   = base_r + ADDR_W'(wr_idx);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bhkv_pkg::S_CLEAR;
      clr_r       <= '0;
      elem_cnt_r  <= '0;
      out_valid_r <= 1'b0;
      scan_r      <= '0;
      hit_r       <= 1'b0;
      free_r      <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (clearing) clr_r <= clr_r + 1'b1;
      if (ld) begin
        elem_cnt_r  <= elem_nxt;
        out_valid_r <= 1'b1;
      end else if (out_rsp.ready) begin
        out_valid_r <= 1'b0;
      end
      if (state_r == bhkv_pkg::S_RDV) begin
        scan_r <= '0;
        hit_r  <= 1'b0;
        free_r <= 1'b0;
      end else if (state_r == bhkv_pkg::S_SCAN) begin
        scan_r <= scan_r + 1'b1;
        if (scan_r != '0) begin
          if (vram_rdata[slot_j]) begin
            if (!hit_r && kv_rdata[bhkv_pkg::KV_W-1:bhkv_pkg::VAL_W] == key_r) begin
              hit_r <= 1'b1;
            end
          end else if (!free_r) begin
            free_r <= 1'b1;
          end
        end
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (div_start) begin
      req_r <= in_req.req_type;
      key_r <= in_req.key;
      val_r <= in_req.value;
    end
    if (div_done) begin
      bucket_r <= div_bucket;
      base_r   <= ADDR_W'(int'(div_bucket) * SLOTS_PER_BUCKET);
    end
    if (state_r == bhkv_pkg::S_SCAN && scan_r != '0) begin
      if (vram_rdata[slot_j]) begin
        if (!hit_r && kv_rdata[bhkv_pkg::KV_W-1:bhkv_pkg::VAL_W] == key_r) begin
          hit_idx_r <= slot_j;
          found_r   <= kv_rdata[bhkv_pkg::VAL_W-1:0];
        end
      end else if (!free_r) begin
        free_idx_r <= slot_j;
      end
    end
    if (ld) begin
      out_status_r <= status_nxt;
      out_found_r  <= found_nxt;
      out_count_r  <= elem_nxt[bhkv_pkg::COUNT_W-1:0];
    end
  end

  assign out_rsp.valid       = out_valid_r;
  assign out_rsp.status      = out_status_r;
  assign out_rsp.found_value = out_found_r;
  assign out_rsp.entry_count = out_count_r;

`ifndef SYNTHESIS
  a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (div_rem < eff_bkt))
    else $error("bucket remainder not below bucket count");

  a_count_moves_on_load: assert property (@(posedge clk) disable iff (!rst_n)
    (elem_cnt_r != $past(elem_cnt_r)) |-> $past(ld))
    else $error("entry count changed without a response load");

  a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    elem_cnt_r <= ELEM_W'(TOTAL_SLOTS))
    else $error("entry count above slot total");

  a_full_only_on_insert: assert property (@(posedge clk) disable iff (!rst_n)
    (ld && status_nxt == bhkv_pkg::ST_FULL) |->
      (!free_r && !hit_r && req_r == bhkv_pkg::REQ_INSERT))
    else $error("bucket full reported without a rejected insert");
`endif

endmodule
